FILE: sv/swb_pkg.sv
// ----------------------------------------------------------------------------
// swb_pkg
// Shared types and codes for the signed word ALU: opcodes, error codes,
// controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package swb_pkg;

	// Default word width of the arithmetic.
	localparam int unsigned WORD_BITS_DEF = 64;

	// Fixed port widths.
	localparam int unsigned OP_W   = 5;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned ERR_W  = 3;
	localparam int unsigned S_TDATA_W = 136;
	localparam int unsigned M_TDATA_W = 72;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_ADD = 5'd0,
		OP_SUB = 5'd1,
		OP_MUL = 5'd2,
		OP_DIV = 5'd3,
		OP_MOD = 5'd4,
		OP_POW = 5'd5,
		OP_SHL = 5'd6,
		OP_SHR = 5'd7,
		OP_LT  = 5'd8,
		OP_LE  = 5'd9,
		OP_GT  = 5'd10,
		OP_GE  = 5'd11,
		OP_EQ  = 5'd12,
		OP_NE  = 5'd13,
		OP_AND = 5'd14,
		OP_XOR = 5'd15,
		OP_OR  = 5'd16
	} op_t;

	// Error codes.
	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 3'd0,
		ERR_DIV_ZERO = 3'd1,
		ERR_MOD_ZERO = 3'd2,
		ERR_NEG_EXP  = 3'd3,
		ERR_BAD_OP   = 3'd4
	} err_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_SHIFT,
		S_MUL,
		S_POW_CHK,
		S_POW_MUL,
		S_POW_SQ,
		S_DONE
	} state_t;

	// Multiplier operand pairs.
	typedef enum logic [1:0] {
		MS_AB,
		MS_ACC_BASE,
		MS_BASE_BASE
	} mul_src_t;

	// Multiplier destinations.
	typedef enum logic {
		MD_ACC,
		MD_BASE
	} mul_dst_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     div_init;
		logic     div_step;
		logic     cnt_step;
		logic     mul_en;
		logic [1:0] mul_phase;
		mul_src_t mul_src;
		mul_dst_t mul_dst;
		logic     pow_init;
		logic     exp_shift;
		logic     finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            b_zero;
		logic            b_neg;
		logic            exp_zero;
		logic            exp_lsb;
		logic            out_full;
	} stat_t;

endpackage

`default_nettype wire

FILE: sv/swb_dpath.sv
// ----------------------------------------------------------------------------
// swb_dpath
// Datapath: operand registers, radix-2 restoring divider, shift count
// reduction, 32x32 partial product multiplier, power registers, result
// selection and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swb_dpath import swb_pkg::*; #(
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	input  wire logic [OP_W-1:0]   in_action,
	input  wire logic [DATA_W-1:0] in_a,
	input  wire logic [DATA_W-1:0] in_b,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [DATA_W-1:0]      out_result,
	output logic [ERR_W-1:0]       out_err
);

	localparam int unsigned EXT     = DATA_W - WORD_BITS;
	localparam int unsigned CNT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int unsigned HALF    = DATA_W / 2;
	localparam int unsigned FOLD_W  = CNT_W + 8;

	// Sign-extend the low WORD_BITS bits to the full word.
	function automatic logic [DATA_W-1:0] norm(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] t;
		t = v << EXT;
		return DATA_W'($signed(t) >>> EXT);
	endfunction

	// Fold one more byte into a remainder modulo the word width. The partial
	// value stays below the width times 256, so eight compare-and-subtract
	// steps bring it back below the width.
	function automatic logic [CNT_W-1:0] fold_byte(input logic [CNT_W-1:0] r,
			input logic [7:0] d);
		logic [FOLD_W-1:0] x;
		x = {r, d};
		for (int j = 7; j >= 0; j--) begin
			if (x >= (FOLD_W'(WORD_BITS) << j))
				x = x - (FOLD_W'(WORD_BITS) << j);
		end
		return x[CNT_W-1:0];
	endfunction

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] a_q, b_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] quo_q, dvs_q;
	logic [DATA_W-1:0] shb_q;
	logic [CNT_W-1:0]  red_q;
	logic [DATA_W-1:0] acc_q, base_q, exp_q;
	logic [DATA_W-1:0] prod_q, macc_q;
	logic              valid_q;
	logic [DATA_W-1:0] result_q;
	logic [ERR_W-1:0]  err_q;

	// Operand capture on an accepted request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_action;
			a_q  <= norm(in_a);
			b_q  <= norm(in_b);
		end
	end

	// Divider: one restoring step per cycle on the operand magnitudes.
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic              take;
	assign rem_sh  = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign take    = ~rem_sub[DATA_W];

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= a_q[DATA_W-1] ? -a_q : a_q;
			dvs_q <= b_q[DATA_W-1] ? -b_q : b_q;
		end else if (cmd.div_step) begin
			rem_q <= take ? rem_sub : rem_sh;
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	// Shift count: the count word modulo the word width, one byte per cycle
	// from the top.
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			shb_q <= b_q;
			red_q <= '0;
		end else if (cmd.cnt_step) begin
			shb_q <= {shb_q[DATA_W-9:0], 8'd0};
			red_q <= fold_byte(red_q, shb_q[DATA_W-1 -: 8]);
		end
	end

	// Multiplier operand selection.
	logic [DATA_W-1:0] mx, my;
	always_comb begin
		case (cmd.mul_src)
			MS_AB:        begin mx = a_q;   my = b_q;    end
			MS_ACC_BASE:  begin mx = acc_q; my = base_q; end
			MS_BASE_BASE: begin mx = base_q; my = base_q; end
			default:      begin mx = a_q;   my = b_q;    end
		endcase
	end

	// One 32x32 product per cycle; only the partial products that reach the
	// low word are formed.
	logic [HALF-1:0]   px, py;
	logic [DATA_W-1:0] mul_fin;
	always_comb begin
		case (cmd.mul_phase)
			2'd0:    begin px = mx[HALF-1:0];      py = my[HALF-1:0];      end
			2'd1:    begin px = mx[HALF-1:0];      py = my[DATA_W-1:HALF]; end
			default: begin px = mx[DATA_W-1:HALF]; py = my[HALF-1:0];      end
		endcase
	end
	assign mul_fin = macc_q + {prod_q[HALF-1:0], {HALF{1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= px * py;
			if (cmd.mul_phase == 2'd1)
				macc_q <= prod_q;
			else if (cmd.mul_phase == 2'd2)
				macc_q <= mul_fin;
		end
	end

	// Power and product registers.
	always_ff @(posedge clk) begin
		if (cmd.pow_init) begin
			acc_q  <= DATA_W'(1);
			base_q <= a_q;
			exp_q  <= b_q;
		end else begin
			if (cmd.mul_en && cmd.mul_phase == 2'd3) begin
				if (cmd.mul_dst == MD_ACC)
					acc_q <= mul_fin;
				else
					base_q <= mul_fin;
			end
			if (cmd.exp_shift)
				exp_q <= exp_q >> 1;
		end
	end

	// Result selection.
	logic [DATA_W-1:0] r;
	logic [ERR_W-1:0]  e;
	logic [CNT_W-1:0]  cnt;
	logic signed [DATA_W-1:0] sa, sb;
	assign cnt = red_q;
	assign sa  = $signed(a_q);
	assign sb  = $signed(b_q);

	always_comb begin
		r = '0;
		e = ERR_NONE;
		case (op_q)
			OP_ADD: r = a_q + b_q;
			OP_SUB: r = a_q - b_q;
			OP_MUL: r = acc_q;
			OP_DIV: begin
				if (b_q == '0) e = ERR_DIV_ZERO;
				else r = (a_q[DATA_W-1] ^ b_q[DATA_W-1]) ? -quo_q : quo_q;
			end
			OP_MOD: begin
				if (b_q == '0) e = ERR_MOD_ZERO;
				else r = a_q[DATA_W-1] ? -rem_q[DATA_W-1:0] : rem_q[DATA_W-1:0];
			end
			OP_POW: begin
				if (b_q[DATA_W-1]) e = ERR_NEG_EXP;
				else r = acc_q;
			end
			OP_SHL: r = a_q << cnt;
			OP_SHR: r = DATA_W'(sa >>> cnt);
			OP_LT:  r = DATA_W'(sa <  sb);
			OP_LE:  r = DATA_W'(sa <= sb);
			OP_GT:  r = DATA_W'(sa >  sb);
			OP_GE:  r = DATA_W'(sa >= sb);
			OP_EQ:  r = DATA_W'(a_q == b_q);
			OP_NE:  r = DATA_W'(a_q != b_q);
			OP_AND: r = a_q & b_q;
			OP_XOR: r = a_q ^ b_q;
			OP_OR:  r = a_q | b_q;
			default: e = ERR_BAD_OP;
		endcase
		if (e != ERR_NONE)
			r = '0;
	end

	// Output register; holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= norm(r);
			err_q    <= e;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;
	assign out_err    = err_q;

	// Status to the controller.
	always_comb begin
		stat.op       = op_q;
		stat.b_zero   = (b_q == '0);
		stat.b_neg    = b_q[DATA_W-1];
		stat.exp_zero = (exp_q == '0);
		stat.exp_lsb  = exp_q[0];
		stat.out_full = valid_q && !out_ready;
	end

endmodule

`default_nettype wire

FILE: sv/swb_ctrl.sv
// ----------------------------------------------------------------------------
// swb_ctrl
// Controller: sequences decode, divider iterations, shift count reduction,
// multiplier phases and square-and-multiply steps, and hands the result to
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swb_ctrl import swb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam int unsigned STEP_W = $clog2(DATA_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);
	localparam logic [STEP_W-1:0] SH_LAST   = STEP_W'(DATA_W / 8 - 1);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        ph_q;
	logic              mul_state;

	assign mul_state = (state_q == S_MUL) || (state_q == S_POW_MUL) || (state_q == S_POW_SQ);

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == S_DIV || state_q == S_SHIFT) ? step_q + 1'b1 : '0;
			ph_q    <= mul_state ? ph_q + 1'b1 : 2'd0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				case (stat.op)
					OP_DIV, OP_MOD: state_d = stat.b_zero ? S_DONE : S_DIV;
					OP_SHL, OP_SHR: state_d = S_SHIFT;
					OP_MUL:         state_d = S_MUL;
					OP_POW:         state_d = stat.b_neg ? S_DONE : S_POW_CHK;
					default:        state_d = S_DONE;
				endcase
			end
			S_DIV:     if (step_q == LAST_STEP) state_d = S_DONE;
			S_SHIFT:   if (step_q == SH_LAST) state_d = S_DONE;
			S_MUL:     if (ph_q == 2'd3) state_d = S_DONE;
			S_POW_CHK: begin
				if (stat.exp_zero)     state_d = S_DONE;
				else if (stat.exp_lsb) state_d = S_POW_MUL;
				else                   state_d = S_POW_SQ;
			end
			S_POW_MUL: if (ph_q == 2'd3) state_d = S_POW_SQ;
			S_POW_SQ:  if (ph_q == 2'd3) state_d = S_POW_CHK;
			S_DONE:    if (!stat.out_full) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd           = '0;
		cmd.mul_src   = MS_AB;
		cmd.mul_dst   = MD_ACC;
		cmd.mul_phase = ph_q;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				cmd.div_init = 1'b1;
				cmd.pow_init = 1'b1;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_SHIFT: cmd.cnt_step = 1'b1;
			S_MUL: cmd.mul_en = 1'b1;
			S_POW_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_src = MS_ACC_BASE;
			end
			S_POW_SQ: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_src   = MS_BASE_BASE;
				cmd.mul_dst   = MD_BASE;
				cmd.exp_shift = (ph_q == 2'd3);
			end
			S_DONE: cmd.finish = !stat.out_full;
			default: ;
		endcase
	end

	// The divider always runs the full word of steps.
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && step_q == LAST_STEP) |=> state_q == S_DONE)
		else $error("divider did not finish after a full word of steps");

	// The multiplier phase only advances inside a multiply state.
	a_ph_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != 2'd0) |-> mul_state)
		else $error("multiplier phase active outside a multiply state");

	// A result is handed over only when the output register is free.
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !stat.out_full)
		else $error("result written over a pending output");

endmodule

`default_nettype wire

FILE: sv/signed_word_binary_alu.sv
// ----------------------------------------------------------------------------
// signed_word_binary_alu
// Signed word ALU: add, sub, mul, div, mod, pow, shifts, compares, bitwise.
// ----------------------------------------------------------------------------
// Usage:
//   One request on the s_ channel carries an opcode and two signed words; one
//   response on the m_ channel carries the word result and an error code.
//   Requests are taken one at a time; a new request is taken while the last
//   response still waits in the output register.
//   Steps from acceptance to the response being offered:
//     add, sub, compares, bitwise and error cases: decode, then hand-over;
//     multiply: four phases of the one 32x32 multiplier;
//     shifts: the count is reduced modulo the word width, one
//     byte of the count word per cycle;
//     divide and remainder: 64 restoring divider steps;
//     power: one square per exponent bit and one multiply per set bit,
//     all on the shared multiplier.
//   Reset clears the controller and the output valid; no request is pending.
//   While the receiver stalls the response holds; a finished request waits
//   until the output register frees before the next one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_word_binary_alu import swb_pkg::*; #(
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// action [4:0], operand_a [68:5], operand_b [132:69], zero [135:133]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// result [63:0], error_code [66:64], zero [71:67]
	output logic [M_TDATA_W-1:0]      m_tdata
);

	cmd_t  cmd;
	stat_t stat;
	logic [DATA_W-1:0] res;
	logic [ERR_W-1:0]  err;

	swb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swb_dpath #(.WORD_BITS(WORD_BITS)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_action  (s_tdata[OP_W-1:0]),
		.in_a       (s_tdata[OP_W +: DATA_W]),
		.in_b       (s_tdata[OP_W+DATA_W +: DATA_W]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_result (res),
		.out_err    (err)
	);

	assign m_tdata = {{(M_TDATA_W-DATA_W-ERR_W){1'b0}}, err, res};

endmodule

`default_nettype wire

FILE: tb/sv/swb_checker.sv
// ----------------------------------------------------------------------------
// swb_checker
// Watches both stream channels of the signed word ALU, works out the expected
// word and error code of every accepted request and compares each response.
// ----------------------------------------------------------------------------
`default_nettype none

module swb_checker import swb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] word;
		err_t        code;
	} answer_t;

	answer_t answers_due[$];

	assign pending = answers_due.size();

	// Square-and-multiply, wrapping modulo 2^64.
	function automatic logic [63:0] wrap_power(logic [63:0] base, logic [63:0] ex);
		logic [63:0] acc;
		acc = 64'd1;
		while (ex != 64'd0) begin
			if (ex[0])
				acc = acc * base;
			base = base * base;
			ex = ex >> 1;
		end
		return acc;
	endfunction

	// Expected response for one request.
	function automatic answer_t alu_answer(logic [4:0] act, logic [63:0] a,
			logic [63:0] b);
		answer_t ans;
		logic [63:0] ma, mb, q;
		ans.word = 64'd0;
		ans.code = ERR_NONE;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		case (act)
			OP_ADD: ans.word = a + b;
			OP_SUB: ans.word = a - b;
			OP_MUL: ans.word = a * b;
			OP_DIV, OP_MOD: begin
				if (b == 64'd0) begin
					ans.code = (act == OP_DIV) ? ERR_DIV_ZERO : ERR_MOD_ZERO;
				end else if (act == OP_DIV) begin
					q = ma / mb;
					ans.word = (a[63] != b[63]) ? -q : q;
				end else begin
					q = ma % mb;
					ans.word = a[63] ? -q : q;
				end
			end
			OP_POW: begin
				if (b[63])
					ans.code = ERR_NEG_EXP;
				else
					ans.word = wrap_power(a, b);
			end
			OP_SHL: ans.word = a << b[5:0];
			OP_SHR: ans.word = $signed(a) >>> b[5:0];
			OP_LT:  ans.word = {63'd0, $signed(a) < $signed(b)};
			OP_LE:  ans.word = {63'd0, $signed(a) <= $signed(b)};
			OP_GT:  ans.word = {63'd0, $signed(a) > $signed(b)};
			OP_GE:  ans.word = {63'd0, $signed(a) >= $signed(b)};
			OP_EQ:  ans.word = {63'd0, a == b};
			OP_NE:  ans.word = {63'd0, a != b};
			OP_AND: ans.word = a & b;
			OP_XOR: ans.word = a ^ b;
			OP_OR:  ans.word = a | b;
			default: ans.code = ERR_BAD_OP;
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("tb: mismatch in %s: got %h, expected %h at %0t", what, got, want,
			$realtime);
		fail_count++;
	endtask

	initial fail_count = 0;

	// Predict on each accepted request, compare on each accepted response.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && s_tvalid && s_tready)
			answers_due.push_back(alu_answer(s_tdata[4:0], s_tdata[68:5],
				s_tdata[132:69]));
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected response", m_tdata[63:0], 64'd0);
			end else begin
				want = answers_due.pop_front();
				if (m_tdata[63:0] !== want.word)
					report_mismatch("result", m_tdata[63:0], want.word);
				if (m_tdata[66:64] !== want.code)
					report_mismatch("error code", m_tdata[66:64], want.code);
				if (m_tdata[71:67] !== 5'd0)
					report_mismatch("padding", m_tdata[71:67], 64'd0);
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into the signed word ALU under several
// idling phases and stall bursts, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import swb_pkg::*;

	localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] WORD_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MINUS_ONE = '1;
	localparam longint CYCLE_LIMIT = 6_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	int                   fail_count;
	int                   pending;
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   hold_cycles;
	longint               cycle_count;

	signed_word_binary_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	swb_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Cycle counter with the run's timeout.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(7))
			0: w = WORD_MIN;
			1: w = WORD_MAX;
			2: w = MINUS_ONE;
			3: w = 64'($signed($urandom_range(20)) - 10);
			4: w = {{32{w[63]}}, w[31:0]};
			default: ;
		endcase
		return w;
	endfunction

	// Offer one request and wait until it is taken. The valid stays high
	// afterwards so that requests can follow back to back.
	task automatic send_request(logic [4:0] act, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'd0, b, a, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [4:0] act;
		logic [63:0] b;
		act = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
		b = rand_word();
		// Keep most exponents short so power stays quick.
		if (act == OP_POW && $urandom_range(3) != 0)
			b = 64'($urandom_range(40));
		send_request(act, rand_word(), b);
	endtask

	initial begin
		op_t op;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation on the extremes, then the special cases.
		op = op.first();
		do begin
			send_request(op, WORD_MIN, WORD_MAX);
			op = op.next();
		end while (op != op.first());
		send_request(OP_DIV, WORD_MIN, MINUS_ONE);
		send_request(OP_MOD, WORD_MIN, MINUS_ONE);
		send_request(OP_DIV, 64'd7, 64'd0);
		send_request(OP_MOD, MINUS_ONE, 64'd0);
		send_request(OP_POW, 64'd3, MINUS_ONE);
		send_request(OP_POW, 64'd0, 64'd0);
		send_request(OP_SHR, WORD_MIN, 64'd127);
		send_request(OP_SHL, MINUS_ONE, WORD_MIN);
		send_request(5'd31, MINUS_ONE, MINUS_ONE);
		send_request(5'd17, 64'd1, 64'd1);
		s_tvalid <= 1'b0;

		// Sender pauses until every response is back.
		while (pending != 0)
			@(posedge clk);

		// Long receiver hold-off while requests keep coming.
		hold_cycles = 400;
		repeat (6) send_random();

		// Random phases: none, sender idle, receiver stall, both.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 35 : 0;
			recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 35 : 0;
			repeat (430) send_random();
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
sv/swb_pkg.sv
sv/swb_dpath.sv
sv/swb_ctrl.sv
sv/signed_word_binary_alu.sv
tb/sv/swb_checker.sv
tb/sv/testbench.sv
